/* rtl/imu_spi_read_scheduler_core_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef IMU_SPI_READ_SCHEDULER_CORE_MACROS_SVH
`define IMU_SPI_READ_SCHEDULER_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define IMU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies a consequence in the following cycle.
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/imu_srs_pkg.sv */
// Types and constants for the inertial sensor SPI read scheduler.
package imu_srs_pkg;

    // Event codes
    localparam logic [2:0] CMD_POLL      = 3'd0;
    localparam logic [2:0] CMD_ACCEL_RDY = 3'd1;
    localparam logic [2:0] CMD_GYRO_RDY  = 3'd2;
    localparam logic [2:0] CMD_XFER_DONE = 3'd3;
    localparam logic [2:0] CMD_XFER_ERR  = 3'd4;
    localparam logic [2:0] CMD_REFUSED   = 3'd5;

    // Read targets and sample kinds
    localparam logic [1:0] TGT_ACCEL = 2'd0;
    localparam logic [1:0] TGT_GYRO  = 2'd1;
    localparam logic [1:0] TGT_TEMP  = 2'd2;

    // Burst start addresses with the read bit set
    localparam logic [7:0] ADDR_ACCEL = 8'h12 | 8'h80;
    localparam logic [7:0] ADDR_GYRO  = 8'h02 | 8'h80;
    localparam logic [7:0] ADDR_TEMP  = 8'h22 | 8'h80;

    // Burst lengths, address byte included
    localparam logic [3:0] LEN_ACCEL = 4'd8;
    localparam logic [3:0] LEN_GYRO  = 4'd7;
    localparam logic [3:0] LEN_TEMP  = 4'd4;

    // Temperature offset: 23 degrees C in eighths
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd184;

    localparam logic [15:0] TEMP_INTERVAL_RESET = 16'd100;

    typedef enum logic [3:0] {
        FL_NONE  = 4'b0001,
        FL_ACCEL = 4'b0010,
        FL_GYRO  = 4'b0100,
        FL_TEMP  = 4'b1000
    } flight_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] rx_byte1;
        logic [7:0] rx_byte2;
        logic [7:0] rx_byte3;
        logic [7:0] rx_byte4;
        logic [7:0] rx_byte5;
        logic [7:0] rx_byte6;
        logic [7:0] rx_byte7;
    } in_item_t;

    typedef struct packed {
        logic              start_read;
        logic [1:0]        read_target;
        logic [7:0]        first_byte;
        logic [3:0]        transfer_bytes;
        logic              release_accel_select;
        logic              release_gyro_select;
        logic              sample_valid;
        logic [1:0]        sample_kind;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
    } out_item_t;

endpackage

/* rtl/imu_spi_read_scheduler_core.sv */
// Burst-read scheduler for a six-axis inertial sensor on one SPI bus.
//
// Each event transfer yields exactly one result transfer. The event is
// decoded, the scheduling flags are updated and the received bytes are
// parsed combinationally, straight into the result register, so one event
// is taken every cycle as long as the result side keeps up; the single
// result register sets that figure, and the event side stalls only while a
// finished result is still waiting to be taken. Gyro reads have priority
// on an idle poll tick, a finished gyro read chains a pending accel read,
// and a finished accel read chains a due temperature read.
// Temperature is reported in eighths of a degree C.
`include "imu_spi_read_scheduler_core_macros.svh"

module imu_spi_read_scheduler_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  imu_srs_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output imu_srs_pkg::out_item_t out_data
);

    import imu_srs_pkg::*;

    logic [15:0] temp_interval_reg;
    flight_t     flight_reg, flight_next;
    logic        accel_pend_reg, accel_pend_next;
    logic        gyro_pend_reg, gyro_pend_next;
    logic        temp_due_reg, temp_due_next;
    logic [15:0] tick_reg, tick_next;
    logic        out_valid_reg;
    out_item_t   out_data_reg, out_data_next;

    logic        in_fire;
    logic        start_req;
    flight_t     start_kind;
    logic [16:0] tick_inc;
    logic [10:0] temp_raw;

    // Accept a new event whenever the result register is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign temp_raw = {in_data.rx_byte2, in_data.rx_byte3[7:5]};

    // Decode the event, update flags and parse bytes
    always_comb
    begin
        flight_next     = flight_reg;
        accel_pend_next = accel_pend_reg;
        gyro_pend_next  = gyro_pend_reg;
        temp_due_next   = temp_due_reg;
        tick_next       = tick_reg;
        out_data_next   = '0;
        start_req       = 1'b0;
        start_kind      = FL_ACCEL;

        case (in_data.cmd)
            CMD_POLL:
            begin
                if (flight_reg == FL_NONE)
                begin
                    if (tick_inc >= {1'b0, temp_interval_reg})
                    begin
                        tick_next     = '0;
                        temp_due_next = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_inc[15:0];
                    end
                    if (gyro_pend_reg)
                    begin
                        gyro_pend_next = 1'b0;
                        start_req      = 1'b1;
                        start_kind     = FL_GYRO;
                    end
                    else if (accel_pend_reg)
                    begin
                        accel_pend_next = 1'b0;
                        start_req       = 1'b1;
                        start_kind      = FL_ACCEL;
                    end
                end
            end
            CMD_ACCEL_RDY: accel_pend_next = 1'b1;
            CMD_GYRO_RDY:  gyro_pend_next  = 1'b1;
            CMD_XFER_DONE:
            begin
                case (flight_reg)
                    FL_ACCEL:
                    begin
                        // Skip the address byte and the dummy byte
                        out_data_next.release_accel_select = 1'b1;
                        out_data_next.sample_valid = 1'b1;
                        out_data_next.sample_kind  = TGT_ACCEL;
                        out_data_next.value_x = {in_data.rx_byte3, in_data.rx_byte2};
                        out_data_next.value_y = {in_data.rx_byte5, in_data.rx_byte4};
                        out_data_next.value_z = {in_data.rx_byte7, in_data.rx_byte6};
                        flight_next = FL_NONE;
                        if (temp_due_reg)
                        begin
                            temp_due_next = 1'b0;
                            start_req     = 1'b1;
                            start_kind    = FL_TEMP;
                        end
                    end
                    FL_GYRO:
                    begin
                        out_data_next.release_gyro_select = 1'b1;
                        out_data_next.sample_valid = 1'b1;
                        out_data_next.sample_kind  = TGT_GYRO;
                        out_data_next.value_x = {in_data.rx_byte2, in_data.rx_byte1};
                        out_data_next.value_y = {in_data.rx_byte4, in_data.rx_byte3};
                        out_data_next.value_z = {in_data.rx_byte6, in_data.rx_byte5};
                        flight_next = FL_NONE;
                        if (accel_pend_reg)
                        begin
                            accel_pend_next = 1'b0;
                            start_req       = 1'b1;
                            start_kind      = FL_ACCEL;
                        end
                    end
                    FL_TEMP:
                    begin
                        // Sign-extend the 11-bit reading and add the offset
                        out_data_next.release_accel_select = 1'b1;
                        out_data_next.sample_valid = 1'b1;
                        out_data_next.sample_kind  = TGT_TEMP;
                        out_data_next.value_x = {{5{temp_raw[10]}}, temp_raw} + TEMP_OFFSET;
                        flight_next = FL_NONE;
                    end
                    default: ;
                endcase
            end
            CMD_XFER_ERR:
            begin
                out_data_next.release_accel_select = 1'b1;
                out_data_next.release_gyro_select  = 1'b1;
                flight_next = FL_NONE;
            end
            CMD_REFUSED:
            begin
                if (flight_reg == FL_GYRO)
                    out_data_next.release_gyro_select = 1'b1;
                else if (flight_reg != FL_NONE)
                    out_data_next.release_accel_select = 1'b1;
                flight_next = FL_NONE;
            end
            default: ;
        endcase

        // Issue the chosen burst
        if (start_req)
        begin
            out_data_next.start_read = 1'b1;
            flight_next = start_kind;
            case (start_kind)
                FL_GYRO:
                begin
                    out_data_next.read_target    = TGT_GYRO;
                    out_data_next.first_byte     = ADDR_GYRO;
                    out_data_next.transfer_bytes = LEN_GYRO;
                end
                FL_TEMP:
                begin
                    out_data_next.read_target    = TGT_TEMP;
                    out_data_next.first_byte     = ADDR_TEMP;
                    out_data_next.transfer_bytes = LEN_TEMP;
                end
                default:
                begin
                    out_data_next.read_target    = TGT_ACCEL;
                    out_data_next.first_byte     = ADDR_ACCEL;
                    out_data_next.transfer_bytes = LEN_ACCEL;
                end
            endcase
        end
    end

    // Hold the interval register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            temp_interval_reg <= TEMP_INTERVAL_RESET;
        else if (cfg_wr_en)
            temp_interval_reg <= cfg_wr_data;
    end

    // Advance scheduling state on each accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg     <= FL_NONE;
            accel_pend_reg <= 1'b0;
            gyro_pend_reg  <= 1'b0;
            temp_due_reg   <= 1'b0;
            tick_reg       <= '0;
        end
        else if (in_fire)
        begin
            flight_reg     <= flight_next;
            accel_pend_reg <= accel_pend_next;
            gyro_pend_reg  <= gyro_pend_next;
            temp_due_reg   <= temp_due_next;
            tick_reg       <= tick_next;
        end
    end

    // Track result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    `IMU_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_valid_reg && !out_ready, !in_ready)
    `IMU_ASSERT_NEXT(a_start_sets_flight, clk, rst_n, in_fire && start_req, flight_reg != FL_NONE)
    `IMU_ASSERT_NEXT(a_error_clears_flight, clk, rst_n, in_fire && in_data.cmd == CMD_XFER_ERR, flight_reg == FL_NONE && out_data_reg.release_accel_select && out_data_reg.release_gyro_select)
    `IMU_ASSERT_SAME(a_temp_yz_zero, clk, rst_n, out_valid_reg && out_data_reg.sample_valid && out_data_reg.sample_kind == TGT_TEMP, out_data_reg.value_y == 16'sd0 && out_data_reg.value_z == 16'sd0)

endmodule

/* tb/sv/imu_spi_read_scheduler_core_tb.sv */
// Self-checking testbench for the inertial sensor SPI read scheduler core.
`timescale 1ns / 100ps

module imu_spi_read_scheduler_core_tb;
    import imu_srs_pkg::*;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned LONG_HOLD   = 60;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    in_item_t    in_data     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    out_item_t   out_data;

    // Shadow copy of the scheduling state
    flight_t     busy_with;
    logic        accel_wanted;
    logic        gyro_wanted;
    logic        temp_wanted;
    logic [15:0] idle_ticks;
    logic [15:0] temp_interval;

    in_item_t    pending_events[$];
    out_item_t   expected_results[$];
    int unsigned queued_events;
    int unsigned failures;
    int unsigned sender_idle_odds;
    int unsigned receiver_idle_odds;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    logic        long_hold_armed = 1'b0;
    logic        long_hold_taken;

    imu_spi_read_scheduler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fill in the request fields and mark the transfer as in flight
    function automatic void launch_read(inout out_item_t r, input flight_t what);
        r.start_read = 1'b1;
        case (what)
            FL_GYRO:
            begin
                r.read_target    = TGT_GYRO;
                r.first_byte     = ADDR_GYRO;
                r.transfer_bytes = LEN_GYRO;
            end
            FL_TEMP:
            begin
                r.read_target    = TGT_TEMP;
                r.first_byte     = ADDR_TEMP;
                r.transfer_bytes = LEN_TEMP;
            end
            default:
            begin
                r.read_target    = TGT_ACCEL;
                r.first_byte     = ADDR_ACCEL;
                r.transfer_bytes = LEN_ACCEL;
            end
        endcase
        busy_with = what;
    endfunction

    // Advance the shadow scheduler by one event and return its result
    function automatic out_item_t predict_event(in_item_t ev);
        out_item_t   r;
        logic [16:0] next_ticks;
        logic [10:0] temp_raw;
        r = '0;
        case (ev.cmd)
            CMD_POLL:
            begin
                if (busy_with == FL_NONE)
                begin
                    next_ticks = {1'b0, idle_ticks} + 17'd1;
                    if (next_ticks >= {1'b0, temp_interval})
                    begin
                        next_ticks  = '0;
                        temp_wanted = 1'b1;
                    end
                    idle_ticks = next_ticks[15:0];
                    if (gyro_wanted)
                    begin
                        gyro_wanted = 1'b0;
                        launch_read(r, FL_GYRO);
                    end
                    else if (accel_wanted)
                    begin
                        accel_wanted = 1'b0;
                        launch_read(r, FL_ACCEL);
                    end
                end
            end
            CMD_ACCEL_RDY:
            begin
                accel_wanted = 1'b1;
            end
            CMD_GYRO_RDY:
            begin
                gyro_wanted = 1'b1;
            end
            CMD_XFER_DONE:
            begin
                case (busy_with)
                    FL_ACCEL:
                    begin
                        r.release_accel_select = 1'b1;
                        r.sample_valid         = 1'b1;
                        r.sample_kind          = TGT_ACCEL;
                        r.value_x              = {ev.rx_byte3, ev.rx_byte2};
                        r.value_y              = {ev.rx_byte5, ev.rx_byte4};
                        r.value_z              = {ev.rx_byte7, ev.rx_byte6};
                        busy_with              = FL_NONE;
                        if (temp_wanted)
                        begin
                            temp_wanted = 1'b0;
                            launch_read(r, FL_TEMP);
                        end
                    end
                    FL_GYRO:
                    begin
                        r.release_gyro_select = 1'b1;
                        r.sample_valid        = 1'b1;
                        r.sample_kind         = TGT_GYRO;
                        r.value_x             = {ev.rx_byte2, ev.rx_byte1};
                        r.value_y             = {ev.rx_byte4, ev.rx_byte3};
                        r.value_z             = {ev.rx_byte6, ev.rx_byte5};
                        busy_with             = FL_NONE;
                        if (accel_wanted)
                        begin
                            accel_wanted = 1'b0;
                            launch_read(r, FL_ACCEL);
                        end
                    end
                    FL_TEMP:
                    begin
                        // 11-bit signed reading, offset to 23 degrees
                        temp_raw               = {ev.rx_byte2, ev.rx_byte3[7:5]};
                        r.release_accel_select = 1'b1;
                        r.sample_valid         = 1'b1;
                        r.sample_kind          = TGT_TEMP;
                        r.value_x              = {{5{temp_raw[10]}}, temp_raw} + TEMP_OFFSET;
                        busy_with              = FL_NONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_XFER_ERR:
            begin
                r.release_accel_select = 1'b1;
                r.release_gyro_select  = 1'b1;
                busy_with              = FL_NONE;
            end
            CMD_REFUSED:
            begin
                if (busy_with == FL_GYRO)
                    r.release_gyro_select = 1'b1;
                else if (busy_with != FL_NONE)
                    r.release_accel_select = 1'b1;
                busy_with = FL_NONE;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Event driver: hold each transfer until accepted, insert random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_event(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_events.size() != 0 && sender_idle_odds != 0 &&
                         $urandom_range(1, sender_idle_odds) == 1)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 10);
                end
                else if (pending_events.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_events.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side ready: one long hold-off when armed, otherwise random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready       <= 1'b1;
            stall_left      <= 0;
            long_hold_taken <= 1'b0;
        end
        else if (long_hold_armed && !long_hold_taken)
        begin
            out_ready       <= 1'b0;
            stall_left      <= LONG_HOLD - 1;
            long_hold_taken <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (receiver_idle_odds != 0 && $urandom_range(1, receiver_idle_odds) == 1)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            failures++;
        end
    endtask

    // Result checker and stall watchdog
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("start_read", want.start_read, out_data.start_read);
                    compare_field("read_target", want.read_target, out_data.read_target);
                    compare_field("first_byte", want.first_byte, out_data.first_byte);
                    compare_field("transfer_bytes", want.transfer_bytes,
                                  out_data.transfer_bytes);
                    compare_field("release_accel_select", want.release_accel_select,
                                  out_data.release_accel_select);
                    compare_field("release_gyro_select", want.release_gyro_select,
                                  out_data.release_gyro_select);
                    compare_field("sample_valid", want.sample_valid, out_data.sample_valid);
                    compare_field("sample_kind", want.sample_kind, out_data.sample_kind);
                    compare_field("value_x", want.value_x, out_data.value_x);
                    compare_field("value_y", want.value_y, out_data.value_y);
                    compare_field("value_z", want.value_z, out_data.value_z);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [55:0] noise_bytes();
        return 56'({$urandom(), $urandom()});
    endfunction

    // Bytes are given as {rx_byte1, ..., rx_byte7}
    task automatic queue_event(logic [2:0] code, logic [55:0] bytes);
        pending_events.push_back(in_item_t'({code, bytes}));
        queued_events++;
    endtask

    // One well-formed round: interrupts, poll ticks, then transfer endings
    task automatic queue_read_round();
        if ($urandom_range(0, 2) != 0)
            queue_event(CMD_GYRO_RDY, noise_bytes());
        if ($urandom_range(0, 2) != 0)
            queue_event(CMD_ACCEL_RDY, noise_bytes());
        repeat ($urandom_range(1, 3))
            queue_event(CMD_POLL, noise_bytes());
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 11))
                0:       queue_event(CMD_XFER_ERR, noise_bytes());
                1:       queue_event(CMD_REFUSED, noise_bytes());
                default: queue_event(CMD_XFER_DONE, noise_bytes());
            endcase
        end
    endtask

    // Keep the driver fed until the requested number of events is queued
    task automatic feed_random(int unsigned count);
        int unsigned goal;
        goal = queued_events + count;
        while (queued_events < goal)
        begin
            if (pending_events.size() < 12)
            begin
                if ($urandom_range(0, 6) != 0)
                    queue_read_round();
                else
                    queue_event(3'($urandom_range(0, 7)), noise_bytes());
            end
            @(posedge clk);
        end
    endtask

    // Wait until every transfer has gone through and the core is quiet
    task automatic settle();
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_interval(logic [15:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        temp_interval = value;
    endtask

    initial
    begin
        busy_with          = FL_NONE;
        accel_wanted       = 1'b0;
        gyro_wanted        = 1'b0;
        temp_wanted        = 1'b0;
        idle_ticks         = '0;
        temp_interval      = TEMP_INTERVAL_RESET;
        queued_events      = 0;
        failures           = 0;
        quiet_cycles       = 0;
        sender_idle_odds   = 0;
        receiver_idle_odds = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every command, both chip paths, chaining, extremes
        set_interval(16'd1);
        queue_event(CMD_XFER_DONE, noise_bytes());
        queue_event(CMD_REFUSED, noise_bytes());
        queue_event(CMD_SPARE_6, {7{8'hFF}});
        queue_event(CMD_SPARE_7, noise_bytes());
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_GYRO_RDY, noise_bytes());
        queue_event(CMD_ACCEL_RDY, noise_bytes());
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_GYRO_RDY, noise_bytes());
        queue_event(CMD_XFER_DONE, {7{8'hFF}});
        queue_event(CMD_XFER_DONE, {7{8'h00}});
        queue_event(CMD_XFER_DONE, 56'h00_7F_E0_00_00_00_00);
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_REFUSED, noise_bytes());
        queue_event(CMD_ACCEL_RDY, noise_bytes());
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_XFER_DONE, 56'hAA_00_80_FF_7F_01_80);
        queue_event(CMD_XFER_DONE, 56'h00_80_00_00_00_00_00);
        queue_event(CMD_ACCEL_RDY, noise_bytes());
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_XFER_DONE, noise_bytes());
        queue_event(CMD_REFUSED, noise_bytes());
        queue_event(CMD_ACCEL_RDY, noise_bytes());
        queue_event(CMD_POLL, noise_bytes());
        queue_event(CMD_XFER_ERR, noise_bytes());
        queue_event(CMD_XFER_ERR, noise_bytes());
        settle();

        // Longest interval: temperature never comes due
        sender_idle_odds   = 4;
        receiver_idle_odds = 4;
        set_interval(16'hFFFF);
        feed_random(120);
        settle();

        // Reset interval, result side held off so the input backs up
        sender_idle_odds   = 0;
        receiver_idle_odds = 0;
        set_interval(TEMP_INTERVAL_RESET);
        long_hold_armed = 1'b1;
        feed_random(100);
        settle();

        // Short random interval, frequent temperature chaining
        sender_idle_odds   = 3;
        receiver_idle_odds = 6;
        set_interval(16'($urandom_range(2, 12)));
        feed_random(200);
        settle();

        sender_idle_odds   = 8;
        receiver_idle_odds = 2;
        set_interval(16'd1);
        feed_random(120);
        settle();

        // Full rate to the end
        sender_idle_odds   = 0;
        receiver_idle_odds = 0;
        set_interval(16'd5);
        feed_random(85);
        settle();
        repeat (5) @(posedge clk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/imu_srs_pkg.sv
rtl/imu_spi_read_scheduler_core.sv
tb/sv/imu_spi_read_scheduler_core_tb.sv
